// File: hdl/mstw_pkg.sv
package mstw_pkg;

    localparam int VERT_W  = 11;
    localparam int WGT_W   = 16;
    localparam int SUM_W   = 28;
    localparam int CNT_W   = 10;
    localparam int CNT_MAX = 1023;

    typedef struct packed {
        logic [VERT_W-1:0] from_v;
        logic [VERT_W-1:0] to_v;
        logic [WGT_W-1:0]  weight;
    } edge_t;

    typedef struct packed {
        logic  valid;
        edge_t e;
    } word_t;

    typedef struct packed {
        logic pop;
        logic clr;
    } chain_ctrl_t;

endpackage

// File: hdl/mstw_if.sv
interface mstw_edge_if;
    logic                        valid;
    logic                        ready;
    logic [mstw_pkg::VERT_W-1:0] edge_from;
    logic [mstw_pkg::VERT_W-1:0] edge_to;
    logic [mstw_pkg::WGT_W-1:0]  edge_weight;
    logic                        last_edge;

    modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
    modport sink (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface mstw_result_if;
    logic                       valid;
    logic                       ready;
    logic [mstw_pkg::SUM_W-1:0] total_weight;
    logic [mstw_pkg::CNT_W-1:0] edges_taken;

    modport source (output valid, total_weight, edges_taken, input ready);
    modport sink (input valid, total_weight, edges_taken, output ready);
endinterface

// File: hdl/minimum_spanning_tree_weight.sv
// Kruskal spanning tree weight. Edges stream in at one word per cycle, while
// the block is loading, into a chain of MAX_EDGES sorting cells; edges beyond
// MAX_EDGES are dropped. After the word marked last, the chain settles while
// each union-find parent entry is set to its own index, one entry a cycle.
// It then pops edges lightest first, one a cycle when no root walk holds it;
// each root walk step for an edge in range takes a read state and a compare
// state (one read port of the parent memory, registered read), then a union
// state follows. One result word gives the summed weight and edge count;
// edges may be loaded for the next graph while it waits.
module minimum_spanning_tree_weight #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mstw_pkg::VERT_W-1:0] cfg_data,
    mstw_edge_if.sink                   edges,
    mstw_result_if.source               result
);

    localparam int VMAX    = (MAX_VERTICES > 2047) ? 2047 : MAX_VERTICES;
    localparam int DEPTH_V = VMAX + 1;
    localparam int AW      = $clog2(DEPTH_V);
    localparam int FILL_W  = $clog2(MAX_EDGES + 1);
    localparam int PREP_N  = ((MAX_EDGES > DEPTH_V) ? MAX_EDGES : DEPTH_V) + 1;
    localparam int PREP_W  = $clog2(PREP_N + 1);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_POP  = 4'd2;
    localparam logic [3:0] S_FXR  = 4'd3;
    localparam logic [3:0] S_FXC  = 4'd4;
    localparam logic [3:0] S_FYR  = 4'd5;
    localparam logic [3:0] S_FYC  = 4'd6;
    localparam logic [3:0] S_UNI  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic [mstw_pkg::VERT_W-1:0] vcount_reg;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [PREP_W-1:0]           prep_reg, prep_next;
    logic [mstw_pkg::VERT_W-1:0] cur_reg, cur_next;
    logic [mstw_pkg::VERT_W-1:0] rx_reg, rx_next;
    logic [mstw_pkg::VERT_W-1:0] ry_reg, ry_next;
    mstw_pkg::edge_t             edge_reg, edge_next;
    logic [mstw_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [mstw_pkg::VERT_W-1:0] taken_reg, taken_next;
    logic                        out_valid_reg, out_valid_next;
    logic [mstw_pkg::SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic [mstw_pkg::CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic [mstw_pkg::VERT_W-1:0] parent_mem [DEPTH_V];
    logic [mstw_pkg::VERT_W-1:0] rdata_reg;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [mstw_pkg::VERT_W-1:0] wdata;
    logic [AW-1:0]               raddr;

    mstw_pkg::chain_ctrl_t       ctrl;
    mstw_pkg::word_t             push_word;
    mstw_pkg::word_t             head;

    logic                        accept;
    logic [mstw_pkg::VERT_W-1:0] n_v, limit_v;
    logic [mstw_pkg::SUM_W:0]    sum_wide;

    assign n_v     = (32'(vcount_reg) > VMAX) ? mstw_pkg::VERT_W'(VMAX) : vcount_reg;
    assign limit_v = (n_v == '0) ? '0 : n_v - 1'b1;

    assign edges.ready = (state_reg == S_LOAD);
    assign accept      = edges.valid && edges.ready;

    assign push_word.valid    = accept && (32'(fill_reg) < MAX_EDGES);
    assign push_word.e.from_v = edges.edge_from;
    assign push_word.e.to_v   = edges.edge_to;
    assign push_word.e.weight = edges.edge_weight;

    mstw_chain #(.DEPTH(MAX_EDGES)) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .push_word (push_word),
        .head      (head)
    );

    always_ff @(posedge clk)
    begin
        if (we)
            parent_mem[waddr] <= wdata;
        rdata_reg <= parent_mem[raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        prep_next      = prep_reg;
        cur_next       = cur_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        edge_next      = edge_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        out_cnt_next   = out_cnt_reg;
        ctrl           = '0;
        we             = 1'b0;
        waddr          = prep_reg[AW-1:0];
        wdata          = mstw_pkg::VERT_W'(prep_reg);
        raddr          = cur_reg[AW-1:0];
        sum_wide       = {1'b0, sum_reg} + (mstw_pkg::SUM_W+1)'(edge_reg.weight);

        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (push_word.valid)
                        fill_next = fill_reg + 1'b1;
                    if (edges.last_edge)
                    begin
                        prep_next  = '0;
                        sum_next   = '0;
                        taken_next = '0;
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                // every vertex starts as its own root
                we        = (32'(prep_reg) < DEPTH_V);
                prep_next = prep_reg + 1'b1;
                if (32'(prep_reg) == PREP_N - 1)
                    state_next = S_POP;
            end
            S_POP:
            begin
                if (!head.valid || (taken_reg >= limit_v))
                    state_next = S_DONE;
                else
                begin
                    ctrl.pop  = 1'b1;
                    edge_next = head.e;
                    cur_next  = head.e.from_v;
                    if ((head.e.from_v != '0) && (head.e.to_v != '0) &&
                        (head.e.from_v <= n_v) && (head.e.to_v <= n_v))
                        state_next = S_FXR;
                end
            end
            S_FXR: state_next = S_FXC;
            S_FXC:
            begin
                if (rdata_reg == cur_reg)
                begin
                    rx_next    = cur_reg;
                    cur_next   = edge_reg.to_v;
                    state_next = S_FYR;
                end
                else
                begin
                    cur_next   = rdata_reg;
                    state_next = S_FXR;
                end
            end
            S_FYR: state_next = S_FYC;
            S_FYC:
            begin
                if (rdata_reg == cur_reg)
                begin
                    ry_next    = cur_reg;
                    state_next = S_UNI;
                end
                else
                begin
                    cur_next   = rdata_reg;
                    state_next = S_FYR;
                end
            end
            S_UNI:
            begin
                if (rx_reg != ry_reg)
                begin
                    we         = 1'b1;
                    waddr      = ry_reg[AW-1:0];
                    wdata      = rx_reg;
                    taken_next = taken_reg + 1'b1;
                    sum_next   = sum_wide[mstw_pkg::SUM_W] ? '1 : sum_wide[mstw_pkg::SUM_W-1:0];
                end
                state_next = S_POP;
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = sum_reg;
                    out_cnt_next   = (32'(taken_reg) > mstw_pkg::CNT_MAX) ?
                                     mstw_pkg::CNT_W'(mstw_pkg::CNT_MAX) :
                                     taken_reg[mstw_pkg::CNT_W-1:0];
                    ctrl.clr       = 1'b1;
                    fill_next      = '0;
                    state_next     = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            vcount_reg    <= mstw_pkg::VERT_W'(1);
            fill_reg      <= '0;
            prep_reg      <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            prep_reg      <= prep_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                vcount_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        edge_reg    <= edge_next;
        sum_reg     <= sum_next;
        out_sum_reg <= out_sum_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.total_weight = out_sum_reg;
    assign result.edges_taken  = out_cnt_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_EDGES)
        else $error("edge fill beyond store depth");

    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UNI) |-> (taken_reg < limit_v))
        else $error("union past the edge limit");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && edges.last_edge) |=> (state_reg == S_PREP) && (prep_reg == '0))
        else $error("last word did not start the pass");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !result.ready) |=> (state_reg == S_DONE))
        else $error("result overwritten while pending");

endmodule

// File: hdl/mstw_cell.sv
module mstw_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mstw_pkg::chain_ctrl_t ctrl,
    input  mstw_pkg::word_t       left_in,
    input  mstw_pkg::word_t       right_held,
    output mstw_pkg::word_t       held,
    output mstw_pkg::word_t       pass_out
);

    mstw_pkg::word_t held_reg;
    mstw_pkg::word_t pass_reg;

    // keep the lighter word, hand the heavier one on; pop shifts towards the head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg.valid <= 1'b0;
            pass_reg.valid <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            held_reg.valid <= 1'b0;
            pass_reg.valid <= 1'b0;
        end
        else if (ctrl.pop)
        begin
            held_reg       <= right_held;
            pass_reg.valid <= 1'b0;
        end
        else if (left_in.valid)
        begin
            if (!held_reg.valid || (left_in.e.weight < held_reg.e.weight))
            begin
                held_reg <= left_in;
                pass_reg <= held_reg;
            end
            else
            begin
                pass_reg <= left_in;
            end
        end
        else
        begin
            pass_reg.valid <= 1'b0;
        end
    end

    assign held     = held_reg;
    assign pass_out = pass_reg;

endmodule

// File: hdl/mstw_chain.sv
module mstw_chain #(
    parameter int DEPTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mstw_pkg::chain_ctrl_t ctrl,
    input  mstw_pkg::word_t       push_word,
    output mstw_pkg::word_t       head
);

    mstw_pkg::word_t held_w [DEPTH];
    mstw_pkg::word_t pass_w [DEPTH];
    mstw_pkg::word_t empty_w;

    assign empty_w = '0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            mstw_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_in    ((i == 0) ? push_word : pass_w[(i == 0) ? 0 : i-1]),
                .right_held ((i == DEPTH-1) ? empty_w : held_w[(i == DEPTH-1) ? i : i+1]),
                .held       (held_w[i]),
                .pass_out   (pass_w[i])
            );
        end
    endgenerate

    // the last cell never passes a word on: the fill count stops at DEPTH
    assign head = held_w[0];

endmodule
